FILE: design/drsa_pkg.sv
// Package: shared types, codes and default sizes for the dual-region slot allocator.
`default_nettype none
package drsa_pkg;

    localparam int DEF_MAX_RECTS    = 64;
    localparam int DEF_MAX_LABELS   = 64;
    localparam int DEF_RECT_BYTES   = 64;
    localparam int DEF_LABEL_BYTES  = 256;
    localparam int DEF_BUFFER_BYTES = 65536;
    localparam int DEF_WAIT_DEPTH   = 16;
    localparam int NUM_QUEUES       = 3;

    typedef enum logic [1:0] {
        MODE_REQUEST = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_IMAGE  = 2'd0,
        KIND_SLIDER = 2'd1,
        KIND_LABEL  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_GRANTED     = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_REL_GRANTED = 3'd2,
        ST_RELEASED    = 3'd3,
        ST_REL_IGNORED = 3'd4,
        ST_QUEUE_FULL  = 3'd5,
        ST_CLEARED     = 3'd6,
        ST_DISABLED    = 3'd7
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  kind;
        logic [15:0] requester_id;
        logic [15:0] release_offset;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_id;
        logic [15:0] granted_offset;
        logic [11:0] granted_index;
    } t_out_item;

endpackage
`default_nettype wire

FILE: design/dual_region_slot_allocator.sv
// Top level: dual-region slot allocator with free stacks and wait queues in memories.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we                  | i_cfg_wdata (enabled)
//
// Per item: the accept cycle reads the free stacks and the wait queue memory, then
// the exec state modifies, writes back and loads the output register; o_in_ready
// stays low in exec, which holds while the output register is full and not taken.
// Synchronous active-low reset; no clearing pass, the memories need none.
`default_nettype none
module dual_region_slot_allocator
    import drsa_pkg::*;
#(
    parameter int MAX_RECTS    = DEF_MAX_RECTS,
    parameter int MAX_LABELS   = DEF_MAX_LABELS,
    parameter int RECT_BYTES   = DEF_RECT_BYTES,
    parameter int LABEL_BYTES  = DEF_LABEL_BYTES,
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
    parameter int WAIT_DEPTH   = DEF_WAIT_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata
);

    localparam int RCW  = $clog2(MAX_RECTS + 1);
    localparam int LCW  = $clog2(MAX_LABELS + 1);
    localparam int RAW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int LAW  = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int QAW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int QLW  = $clog2(WAIT_DEPTH + 1);
    localparam int WMD  = NUM_QUEUES * WAIT_DEPTH;
    localparam int WMW  = $clog2(WMD);
    localparam int LB_RESET = BUFFER_BYTES - LABEL_BYTES;

    localparam logic [16:0] RECT_STEP  = 17'(RECT_BYTES);
    localparam logic [15:0] LABEL_STEP = 16'(LABEL_BYTES);
    localparam logic [15:0] LABEL_INIT = 16'(LB_RESET);

    // control state
    t_state            r_state, n_state;
    logic              r_enabled;
    logic [RCW-1:0]    r_rect_count, n_rect_count;
    logic [LCW-1:0]    r_label_count, n_label_count;
    logic [16:0]       r_rect_top, n_rect_top;
    logic [15:0]       r_label_bottom, n_label_bottom;
    logic [RCW-1:0]    r_rect_depth, n_rect_depth;
    logic [LCW-1:0]    r_label_depth, n_label_depth;
    logic [QAW-1:0]    r_head [0:NUM_QUEUES-1];
    logic [QAW-1:0]    n_head [0:NUM_QUEUES-1];
    logic [QLW-1:0]    r_len  [0:NUM_QUEUES-1];
    logic [QLW-1:0]    n_len  [0:NUM_QUEUES-1];
    logic              r_out_valid;

    // payload
    t_in_item          r_item;
    t_out_item         r_out, n_out;
    logic [15:0]       r_rect_rd, r_label_rd, r_wait_rd;

    // memories
    logic [15:0]       r_rect_mem  [0:MAX_RECTS-1];
    logic [15:0]       r_label_mem [0:MAX_LABELS-1];
    logic [15:0]       r_wait_mem  [0:WMD-1];

    logic              accept, exec_go, has_result;
    logic              rect_we, label_we, wait_we;
    logic [RAW-1:0]    rect_wa;
    logic [LAW-1:0]    label_wa;
    logic [WMW-1:0]    wait_wa, wait_ra;
    logic [15:0]       mem_wd;
    logic [1:0]        qsel, in_qsel;

    function automatic logic [1:0] queue_of(input logic [1:0] kind);
        logic [1:0] q;
        q = 2'd0;
        if (kind == KIND_SLIDER) q = 2'd1;
        else if (kind == KIND_LABEL) q = 2'd2;
        return q;
    endfunction

    function automatic logic [WMW-1:0] wait_addr(input logic [1:0] q,
                                                 input logic [QAW-1:0] idx);
        return WMW'(q) * WMW'(WAIT_DEPTH) + WMW'(idx);
    endfunction

    assign accept  = i_in_valid && o_in_ready;
    assign in_qsel = queue_of(i_in_item.kind);
    assign qsel    = queue_of(r_item.kind);
    assign wait_ra = wait_addr(in_qsel, r_head[in_qsel]);
    assign exec_go = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: if (exec_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = r_out_valid;
        o_out_item  = r_out;
    end

    // read-modify-write datapath of the exec cycle
    always_comb begin
        logic        is_label, pushed, edge_hit;
        logic [QLW:0] tsum;
        logic [QAW:0] hsum;
        logic [15:0] off;
        logic [15:0] who;
        logic [2:0]  st;

        n_rect_count   = r_rect_count;
        n_label_count  = r_label_count;
        n_rect_top     = r_rect_top;
        n_label_bottom = r_label_bottom;
        n_rect_depth   = r_rect_depth;
        n_label_depth  = r_label_depth;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            n_head[q] = r_head[q];
            n_len[q]  = r_len[q];
        end
        rect_we  = 1'b0;
        label_we = 1'b0;
        wait_we  = 1'b0;
        rect_wa  = r_rect_depth[RAW-1:0];
        label_wa = r_label_depth[LAW-1:0];
        mem_wd   = r_item.release_offset;
        is_label = (r_item.kind == KIND_LABEL);
        pushed   = 1'b0;
        edge_hit = 1'b0;
        off      = 16'd0;
        who      = 16'd0;
        st       = ST_DISABLED;
        has_result = 1'b1;

        tsum = {1'b0, QLW'(r_head[qsel])} + {1'b0, r_len[qsel]};
        if (tsum >= (QLW+1)'(WAIT_DEPTH)) tsum = tsum - (QLW+1)'(WAIT_DEPTH);
        wait_wa = wait_addr(qsel, tsum[QAW-1:0]);
        hsum = {1'b0, r_head[qsel]} + (QAW+1)'(1);
        if (hsum >= (QAW+1)'(WAIT_DEPTH)) hsum = hsum - (QAW+1)'(WAIT_DEPTH);

        if (!r_enabled) begin
            st = ST_DISABLED;
        end else if (r_item.mode == MODE_CLEAR) begin
            st             = ST_CLEARED;
            n_rect_count   = '0;
            n_label_count  = '0;
            n_rect_top     = '0;
            n_label_bottom = LABEL_INIT;
            n_rect_depth   = '0;
            n_label_depth  = '0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                n_head[q] = '0;
                n_len[q]  = '0;
            end
        end else if (r_item.mode == MODE_NONE || r_item.kind == KIND_NONE) begin
            has_result = 1'b0;
        end else if (r_item.mode == MODE_REQUEST) begin
            if (is_label ? (r_label_count < LCW'(MAX_LABELS))
                         : (r_rect_count < RCW'(MAX_RECTS))) begin
                st  = ST_GRANTED;
                who = r_item.requester_id;
                if (is_label) begin
                    n_label_count = r_label_count + LCW'(1);
                    if (r_label_depth != '0) begin
                        off           = r_label_rd;
                        n_label_depth = r_label_depth - LCW'(1);
                    end else begin
                        off            = r_label_bottom;
                        n_label_bottom = r_label_bottom - LABEL_STEP;
                    end
                end else begin
                    n_rect_count = r_rect_count + RCW'(1);
                    if (r_rect_depth != '0) begin
                        off          = r_rect_rd;
                        n_rect_depth = r_rect_depth - RCW'(1);
                    end else begin
                        off        = r_rect_top[15:0];
                        n_rect_top = r_rect_top + RECT_STEP;
                    end
                end
            end else if (r_len[qsel] >= QLW'(WAIT_DEPTH)) begin
                st = ST_QUEUE_FULL;
            end else begin
                st           = ST_QUEUED;
                wait_we      = 1'b1;
                mem_wd       = r_item.requester_id;
                n_len[qsel]  = r_len[qsel] + QLW'(1);
            end
        end else if (is_label ? (r_label_count == '0) : (r_rect_count == '0)) begin
            st = ST_REL_IGNORED;
        end else begin
            // give back first, then hand a slot to the oldest waiter of this kind
            if (is_label) begin
                n_label_count = r_label_count - LCW'(1);
                edge_hit = ({1'b0, r_item.release_offset} ==
                            ({1'b0, r_label_bottom} + {1'b0, LABEL_STEP}));
                if (edge_hit) n_label_bottom = r_item.release_offset;
                else if (r_label_depth < LCW'(MAX_LABELS)) pushed = 1'b1;
            end else begin
                n_rect_count = r_rect_count - RCW'(1);
                edge_hit = ({1'b0, r_item.release_offset} == (r_rect_top - RECT_STEP));
                if (edge_hit) n_rect_top = {1'b0, r_item.release_offset};
                else if (r_rect_depth < RCW'(MAX_RECTS)) pushed = 1'b1;
            end
            if (r_len[qsel] != '0) begin
                st           = ST_REL_GRANTED;
                who          = r_wait_rd;
                n_head[qsel] = hsum[QAW-1:0];
                n_len[qsel]  = r_len[qsel] - QLW'(1);
                if (is_label) begin
                    n_label_count = r_label_count;
                    if (pushed) begin
                        off = r_item.release_offset;
                    end else if (r_label_depth != '0) begin
                        off           = r_label_rd;
                        n_label_depth = r_label_depth - LCW'(1);
                    end else begin
                        off            = n_label_bottom;
                        n_label_bottom = n_label_bottom - LABEL_STEP;
                    end
                end else begin
                    n_rect_count = r_rect_count;
                    if (pushed) begin
                        off = r_item.release_offset;
                    end else if (r_rect_depth != '0) begin
                        off          = r_rect_rd;
                        n_rect_depth = r_rect_depth - RCW'(1);
                    end else begin
                        off        = n_rect_top[15:0];
                        n_rect_top = n_rect_top + RECT_STEP;
                    end
                end
            end else begin
                st = ST_RELEASED;
                if (pushed && is_label) begin
                    label_we      = 1'b1;
                    n_label_depth = r_label_depth + LCW'(1);
                end else if (pushed) begin
                    rect_we      = 1'b1;
                    n_rect_depth = r_rect_depth + RCW'(1);
                end
            end
        end

        n_out.status         = st;
        n_out.granted_id     = who;
        n_out.granted_offset = off;
        n_out.granted_index  = off[15:4];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_enabled      <= 1'b1;
            r_rect_count   <= '0;
            r_label_count  <= '0;
            r_rect_top     <= '0;
            r_label_bottom <= LABEL_INIT;
            r_rect_depth   <= '0;
            r_label_depth  <= '0;
            r_out_valid    <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q] <= '0;
                r_len[q]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_enabled <= i_cfg_wdata;
            if (exec_go) begin
                r_rect_count   <= n_rect_count;
                r_label_count  <= n_label_count;
                r_rect_top     <= n_rect_top;
                r_label_bottom <= n_label_bottom;
                r_rect_depth   <= n_rect_depth;
                r_label_depth  <= n_label_depth;
                for (int q = 0; q < NUM_QUEUES; q++) begin
                    r_head[q] <= n_head[q];
                    r_len[q]  <= n_len[q];
                end
            end
            if (exec_go && has_result) r_out_valid <= 1'b1;
            else if (i_out_ready)      r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_in_item;
        if (exec_go && has_result) r_out <= n_out;
    end

    // memories: read at the top of stack and queue head on accept, write on exec
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rect_rd  <= r_rect_mem[RAW'(r_rect_depth - RCW'(1))];
            r_label_rd <= r_label_mem[LAW'(r_label_depth - LCW'(1))];
            r_wait_rd  <= r_wait_mem[wait_ra];
        end
        if (exec_go && rect_we)  r_rect_mem[rect_wa]   <= mem_wd;
        if (exec_go && label_we) r_label_mem[label_wa] <= mem_wd;
        if (exec_go && wait_we)  r_wait_mem[wait_wa]   <= mem_wd;
    end

endmodule
`default_nettype wire

FILE: design/drsa_checker.sv
// Port-level checker for the dual-region slot allocator, bound to the top level.
`default_nettype none
module drsa_checker
    import drsa_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // one item at a time: busy right after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a second item back to back");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.granted_index == o_out_item.granted_offset[15:4])
        else $error("index does not match offset");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_GRANTED
            && o_out_item.status != ST_REL_GRANTED
        |-> o_out_item.granted_id == 16'd0 && o_out_item.granted_offset == 16'd0)
        else $error("non-grant result carries slot data");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind dual_region_slot_allocator drsa_checker u_drsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire

FILE: tb/sv/tb_dual_region_slot_allocator.sv
// Testbench for the dual-region slot allocator: directed and random transfers against a predictor.
`timescale 1ns / 100ps
module tb_dual_region_slot_allocator;
    import drsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    dual_region_slot_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // allocator shadow state
    bit          alloc_on;
    int unsigned rects_used, labels_used;
    bit [16:0]   rect_edge;
    bit [15:0]   label_edge;
    bit [15:0]   rect_freed[$];
    bit [15:0]   label_freed[$];
    bit [15:0]   waiters[NUM_QUEUES][$];

    t_out_item   expected_grants[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          watchdog = 0;

    function automatic void wipe_allocator();
        rects_used = 0;
        labels_used = 0;
        rect_edge = '0;
        label_edge = 16'(DEF_BUFFER_BYTES - DEF_LABEL_BYTES);
        rect_freed.delete();
        label_freed.delete();
        for (int q = 0; q < NUM_QUEUES; q++) waiters[q].delete();
    endfunction

    function automatic bit [15:0] take_slot(bit lbl);
        bit [15:0] off;
        if (lbl) begin
            if (label_freed.size() > 0) begin
                off = label_freed[$];
                label_freed.delete(label_freed.size() - 1);
            end else begin
                off = label_edge;
                label_edge = label_edge - 16'(DEF_LABEL_BYTES);
            end
            labels_used++;
        end else begin
            if (rect_freed.size() > 0) begin
                off = rect_freed[$];
                rect_freed.delete(rect_freed.size() - 1);
            end else begin
                off = rect_edge[15:0];
                rect_edge = rect_edge + 17'(DEF_RECT_BYTES);
            end
            rects_used++;
        end
        return off;
    endfunction

    function automatic void give_back(bit lbl, bit [15:0] off);
        if (lbl) begin
            labels_used--;
            // edge compare is done at 17 bits, no wrap
            if (17'(off) == 17'(label_edge) + 17'(DEF_LABEL_BYTES)) label_edge = off;
            else if (label_freed.size() < DEF_MAX_LABELS)
                label_freed.insert(label_freed.size(), off);
        end else begin
            rects_used--;
            if (17'(off) == rect_edge - 17'(DEF_RECT_BYTES)) rect_edge = 17'(off);
            else if (rect_freed.size() < DEF_MAX_RECTS)
                rect_freed.insert(rect_freed.size(), off);
        end
    endfunction

    function automatic t_out_item make_grant(t_status st, bit [15:0] id, bit [15:0] off);
        t_out_item r;
        r.status = st;
        r.granted_id = id;
        r.granted_offset = off;
        r.granted_index = off[15:4];
        return r;
    endfunction

    function automatic void expect_result(t_out_item r);
        expected_grants.insert(expected_grants.size(), r);
    endfunction

    function automatic void predict_allocation(t_in_item it);
        bit lbl;
        int unsigned used;
        bit [15:0] off;
        lbl = (it.kind == KIND_LABEL);
        if (!alloc_on) begin
            expect_result(make_grant(ST_DISABLED, 0, 0));
            return;
        end
        if (it.mode == MODE_CLEAR) begin
            wipe_allocator();
            expect_result(make_grant(ST_CLEARED, 0, 0));
            return;
        end
        if (it.mode == MODE_NONE || it.kind == KIND_NONE) return;
        used = lbl ? labels_used : rects_used;
        if (it.mode == MODE_REQUEST) begin
            if (used < (lbl ? DEF_MAX_LABELS : DEF_MAX_RECTS)) begin
                off = take_slot(lbl);
                expect_result(make_grant(ST_GRANTED, it.requester_id, off));
            end else if (waiters[it.kind].size() >= DEF_WAIT_DEPTH) begin
                expect_result(make_grant(ST_QUEUE_FULL, 0, 0));
            end else begin
                waiters[it.kind].insert(waiters[it.kind].size(), it.requester_id);
                expect_result(make_grant(ST_QUEUED, 0, 0));
            end
            return;
        end
        if (used == 0) begin
            expect_result(make_grant(ST_REL_IGNORED, 0, 0));
            return;
        end
        give_back(lbl, it.release_offset);
        if (waiters[it.kind].size() > 0) begin
            bit [15:0] who;
            who = waiters[it.kind].pop_front();
            off = take_slot(lbl);
            expect_result(make_grant(ST_REL_GRANTED, who, off));
        end else begin
            expect_result(make_grant(ST_RELEASED, 0, 0));
        end
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_item);
            end else begin
                t_out_item e;
                e = expected_grants.pop_front();
                if (o_out_item !== e) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, o_out_item);
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("tb_dual_region_slot_allocator failed");
            $finish;
        end
    end

    // valid stays up after a transfer until the next item or an idle cycle
    task automatic send_item(t_mode md, t_kind kd, bit [15:0] id, bit [15:0] off);
        t_in_item it;
        it.mode = md;
        it.kind = kd;
        it.requester_id = id;
        it.release_offset = off;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_allocation(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_enable(bit val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        alloc_on = val;
        i_cfg_we <= 1'b0;
    endtask

    function automatic bit [15:0] pick_release(t_kind kd);
        bit [15:0] off;
        if ($urandom_range(9) == 0) return 16'($urandom);
        if (kd == KIND_LABEL)
            off = 16'(DEF_BUFFER_BYTES - DEF_LABEL_BYTES * (1 + $urandom_range(63)));
        else
            off = 16'(DEF_RECT_BYTES * $urandom_range(63));
        return off;
    endfunction

    task automatic test_directed_extremes();
        send_item(MODE_REQUEST, KIND_IMAGE, 16'h0000, 16'hFFFF);
        send_item(MODE_REQUEST, KIND_SLIDER, 16'hFFFF, 16'h0000);
        send_item(MODE_REQUEST, KIND_LABEL, 16'hA5A5, 16'h5A5A);
        send_item(MODE_RELEASE, KIND_IMAGE, 16'h1234, 16'd0);      // not edge: to stack
        send_item(MODE_REQUEST, KIND_IMAGE, 16'h5678, 16'h0);      // reuse from stack
        send_item(MODE_RELEASE, KIND_SLIDER, 16'h0, 16'd64);       // edge slot
        send_item(MODE_RELEASE, KIND_LABEL, 16'h0, 16'hFF00);      // label edge
        send_item(MODE_RELEASE, KIND_LABEL, 16'h0, 16'hFF00);      // count zero: ignored
        send_item(MODE_NONE, KIND_IMAGE, 16'h1, 16'h1);            // no result
        send_item(MODE_REQUEST, KIND_NONE, 16'h2, 16'h2);          // no result
        send_item(MODE_RELEASE, KIND_NONE, 16'h3, 16'h3);          // no result
        send_item(MODE_CLEAR, KIND_NONE, 16'hFFFF, 16'hFFFF);
        send_item(MODE_RELEASE, KIND_IMAGE, 16'hFFFF, 16'hFFFF);   // ignored after clear
    endtask

    // fill both regions, overflow wait queues, then drain them through releases
    task automatic test_full_regions();
        for (int i = 0; i < 64 + 17; i++) send_item(MODE_REQUEST, KIND_IMAGE, 16'(i), 0);
        for (int i = 0; i < 17; i++) send_item(MODE_REQUEST, KIND_SLIDER, 16'(i + 300), 0);
        for (int i = 0; i < 64 + 17; i++) send_item(MODE_REQUEST, KIND_LABEL, 16'(i + 600), 0);
        for (int i = 0; i < 20; i++) send_item(MODE_RELEASE, KIND_SLIDER, 0, pick_release(KIND_SLIDER));
        for (int i = 0; i < 20; i++) send_item(MODE_RELEASE, KIND_LABEL, 0, pick_release(KIND_LABEL));
        for (int i = 0; i < 20; i++) send_item(MODE_RELEASE, KIND_IMAGE, 0, pick_release(KIND_IMAGE));
    endtask

    task automatic test_disabled();
        write_enable(1'b0);
        send_item(MODE_REQUEST, KIND_IMAGE, 16'h77, 0);
        send_item(MODE_CLEAR, KIND_LABEL, 0, 0);
        send_item(MODE_NONE, KIND_NONE, 16'hFFFF, 16'hFFFF);
        write_enable(1'b1);
    endtask

    task automatic test_random(int n);
        t_mode md;
        t_kind kd;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            md = (r < 55) ? MODE_REQUEST : (r < 95) ? MODE_RELEASE : (r < 98) ? MODE_CLEAR : MODE_NONE;
            kd = t_kind'(($urandom_range(49) == 0) ? 3 : $urandom_range(2));
            send_item(md, kd, 16'($urandom), pick_release(kd));
        end
    endtask

    initial begin
        alloc_on = 1'b1;
        wipe_allocator();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_full_regions();
        test_disabled();
        test_random(46);
        wait_drained();                // sender holds off until all results are in
        send_idle_pct = 65;
        test_random(46);
        send_idle_pct = 0;
        recv_stall_pct = 65;
        test_random(46);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        test_random(46);
        write_enable(1'b0);
        test_random(5);
        write_enable(1'b1);
        test_random(5);
        wait_drained();

        if (mismatches == 0 && expected_grants.size() == 0) begin
            $display("tb_dual_region_slot_allocator passed");
        end else begin
            $display("tb_dual_region_slot_allocator failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/drsa_pkg.sv
design/dual_region_slot_allocator.sv
design/drsa_checker.sv
tb/sv/tb_dual_region_slot_allocator.sv
